// ----- hdl/fbml_pkg.sv -----
// ----------------------------------------------------------------------------
// fbml_pkg: shared types and constants of the free block MRU list
// Operation codes, controller state type and the command and status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package fbml_pkg;

  localparam int ADDR_W               = 48;
  localparam int FUNC_W               = 2;
  localparam int LIST_ENTRIES_DEFAULT = 8;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_APPEND  = 2'd0,
    FUNC_REMOVE  = 2'd1,
    FUNC_REPLACE = 2'd2,
    FUNC_NONE    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_SCAN,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic load;
    logic compare;
    logic scan;
    logic update;
  } cmd_t;

  typedef struct packed {
    logic stop;
  } status_t;

endpackage

`default_nettype wire

// ----- hdl/fbml_ctrl.sv -----
// ----------------------------------------------------------------------------
// fbml_ctrl: sequencer of the free block MRU list
// Takes one request at a time, steps the datapath through compare, scan
// and update, and keeps the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module fbml_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output fbml_pkg::cmd_t        cmd,
  input  wire fbml_pkg::status_t status
);

  fbml_pkg::state_t state, state_next;
  logic             out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fbml_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    in_stall       = 1'b1;
    out_valid_next = out_valid && out_stall;
    unique case (state)
      fbml_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = fbml_pkg::ST_CMP;
        end
      end
      fbml_pkg::ST_CMP: begin
        cmd.compare = 1'b1;
        state_next  = fbml_pkg::ST_SCAN;
      end
      fbml_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.stop) state_next = fbml_pkg::ST_UPDATE;
      end
      fbml_pkg::ST_UPDATE: begin
        if (!(out_valid && out_stall)) begin
          cmd.update     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = fbml_pkg::ST_IDLE;
        end
      end
      default: state_next = fbml_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/fbml_datapath.sv -----
// ----------------------------------------------------------------------------
// fbml_datapath: slot list, match vector, scan counter and result register
// Compares every slot with the key, scans for the first match one slot a
// cycle, then shifts the list around the found slot in one step.
// ----------------------------------------------------------------------------
`default_nettype none

module fbml_datapath #(
  parameter int LIST_ENTRIES = fbml_pkg::LIST_ENTRIES_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [fbml_pkg::FUNC_W-1:0] func,
  input  wire logic [fbml_pkg::ADDR_W-1:0] addr,
  input  wire logic [fbml_pkg::ADDR_W-1:0] new_addr,
  output logic                             found,
  input  wire fbml_pkg::cmd_t              cmd,
  output fbml_pkg::status_t                status
);

  localparam int IDX_W = (LIST_ENTRIES > 1) ? $clog2(LIST_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(LIST_ENTRIES - 1);

  fbml_pkg::func_t             op;
  logic [fbml_pkg::ADDR_W-1:0] key;
  logic [fbml_pkg::ADDR_W-1:0] front;
  logic [fbml_pkg::ADDR_W-1:0] slot      [LIST_ENTRIES];
  logic [fbml_pkg::ADDR_W-1:0] slot_next [LIST_ENTRIES];
  logic [LIST_ENTRIES-1:0]     match;
  logic [IDX_W-1:0]            idx;
  logic [IDX_W-1:0]            pos;
  logic                        hit;
  logic                        scan_hit;
  logic                        scan_last;
  logic                        do_update;
  logic                        found_next;

  assign scan_hit    = match[idx];
  assign scan_last   = (idx == IDX_LAST);
  assign status.stop = scan_hit || scan_last;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op    <= fbml_pkg::func_t'(func);
      key   <= (fbml_pkg::func_t'(func) == fbml_pkg::FUNC_APPEND) ? '0 : addr;
      front <= (fbml_pkg::func_t'(func) == fbml_pkg::FUNC_APPEND) ? addr : new_addr;
    end
    if (cmd.compare) begin
      for (int k = 0; k < LIST_ENTRIES; k++) match[k] <= (slot[k] == key);
    end
    if (cmd.scan && status.stop) begin
      pos <= idx;
      hit <= scan_hit;
    end
    if (cmd.update) found <= found_next;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.compare) begin
      idx <= '0;
    end else if (cmd.scan && !status.stop) begin
      idx <= idx + 1'b1;
    end
  end

  always_comb begin
    unique case (op)
      fbml_pkg::FUNC_APPEND: begin
        do_update  = 1'b1;
        found_next = 1'b1;
      end
      fbml_pkg::FUNC_REMOVE, fbml_pkg::FUNC_REPLACE: begin
        do_update  = hit;
        found_next = hit;
      end
      default: begin
        do_update  = 1'b0;
        found_next = 1'b0;
      end
    endcase
  end

  always_comb begin
    for (int k = 0; k < LIST_ENTRIES; k++) begin
      slot_next[k] = slot[k];
      if (op == fbml_pkg::FUNC_REMOVE) begin
        if (IDX_W'(k) >= pos) begin
          slot_next[k] = (k == LIST_ENTRIES - 1) ? '0 : slot[(k + 1) % LIST_ENTRIES];
        end
      end else if (IDX_W'(k) <= pos) begin
        slot_next[k] = (k == 0) ? front : slot[(k + LIST_ENTRIES - 1) % LIST_ENTRIES];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LIST_ENTRIES; k++) slot[k] <= '0;
    end else if (cmd.update && do_update) begin
      for (int k = 0; k < LIST_ENTRIES; k++) slot[k] <= slot_next[k];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/free_block_mru_list_unit.sv -----
// ----------------------------------------------------------------------------
// free_block_mru_list_unit: most-recent-first list of free block addresses
// Input channel (in_valid/in_stall) carries one request: func, addr and
// new_addr. Append pushes addr in at the front, remove takes out the first
// slot equal to addr, replace moves new_addr to the front in place of addr.
// Output channel (out_valid/out_stall) returns one found flag per request.
// A request goes through a compare step, a scan of one slot a cycle that
// stops at the first matching slot or at the last slot, and an update step
// in which found is registered.
// The next request is taken in the cycle after the update, so a request is
// taken only once the one before it is through.
// The result register parts the two sides: a new request is taken while a
// result waits; a request held by a stalled result waits in its update step
// until the result is taken.
// Reset empties every slot and drops any pending result.
// ----------------------------------------------------------------------------
`default_nettype none

module free_block_mru_list_unit #(
  parameter int LIST_ENTRIES = fbml_pkg::LIST_ENTRIES_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [fbml_pkg::FUNC_W-1:0] func,
  input  wire logic [fbml_pkg::ADDR_W-1:0] addr,
  input  wire logic [fbml_pkg::ADDR_W-1:0] new_addr,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             found
);

  fbml_pkg::cmd_t    cmd;
  fbml_pkg::status_t status;

  fbml_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  fbml_datapath #(
    .LIST_ENTRIES (LIST_ENTRIES)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .func     (func),
    .addr     (addr),
    .new_addr (new_addr),
    .found    (found),
    .cmd      (cmd),
    .status   (status)
  );

endmodule

`default_nettype wire
